// ===== rtl/mpgc_pkg.sv =====
`timescale 1ns / 1ps

package mpgc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_ADJ,
    ST_TSC,
    ST_RCP,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    CFG_GAIN      = 2'd0,
    CFG_OFFSET    = 2'd1,
    CFG_WINDOW    = 2'd2,
    CFG_THRESHOLD = 2'd3
  } cfg_idx_t;

  localparam logic [15:0] FALLBACK_RAW = 16'hFFFF;
  localparam logic [15:0] FALLBACK_DEN = 16'd1;
  localparam logic [12:0] PRESS_MAX    = 13'd6000;
  localparam logic signed [33:0] Q_LIMIT = 34'sd75000;
  localparam logic signed [21:0] SCALE_RND = 22'sd125;
  // ceil(2^29 / 250); exact floor(t / 250) for 0 < t < 2^21
  localparam logic [21:0] RECIP_M      = 22'd2147484;
  localparam int          RECIP_SHIFT  = 29;
  localparam int          DIV_STEPS    = 32;
  localparam int          DIV_CNT_W    = $clog2(DIV_STEPS);

endpackage

// ===== rtl/manifold_pressure_gradient_check_unit.sv =====
`timescale 1ns / 1ps
// Sequence: a sample item passes the multiply, divide (a 32-step restoring
// divider), adjust, scale, reciprocal and finish steps to out_valid; a restart item
// goes straight to finish. Only one item is in flight at a time; in_stall is high from
// acceptance until the result is written to the output register, which then frees
// the input. A stalled result holds the finish step.
// Reset (rst_n low, synchronous): configuration registers, window counter, reference and fault clear.
module manifold_pressure_gradient_check_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [15:0] in_raw_pressure,
  input  logic [15:0] in_supply_voltage,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [12:0] out_pressure,
  output logic [12:0] out_reference_pressure,
  output logic [7:0]  out_window_position,
  output logic        out_gradient_fault,
  output logic        out_check_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  mpgc_pkg::state_t state_r, state_nxt;

  logic [15:0]        gain_r;
  logic signed [15:0] offset_r;
  logic [7:0]         wlen_r;
  logic [7:0]         thr_r;

  logic [7:0]  wcount_r;
  logic [12:0] ref_r;
  logic [12:0] last_r;
  logic        fault_r;

  logic        req_r;
  logic [15:0] num_r;
  logic [15:0] den_r;
  logic [31:0] quo_r;
  logic [15:0] rem_r;
  logic [mpgc_pkg::DIV_CNT_W-1:0] cnt_r;
  logic        sat_r;
  logic signed [17:0] s_r;
  logic signed [21:0] t_r;
  logic [42:0] prod_r;

  logic        out_valid_r;
  logic [12:0] out_press_r;
  logic [12:0] out_ref_r;
  logic [7:0]  out_wpos_r;
  logic        out_fault_r;
  logic        out_done_r;

  logic accept;
  logic fin_go;
  logic is_rcp;

  // shared multiplier: gain product first, reciprocal scaling later
  logic [20:0] mul_a;
  logic [21:0] mul_b;
  logic [42:0] mul_p;

  logic [16:0] rem_sh;
  logic        rem_ge;
  logic signed [33:0] s_full;
  logic signed [21:0] s_ext;
  logic signed [21:0] t_calc;
  logic        t_pos;

  logic [12:0] p_new;
  logic [7:0]  wc_new;
  logic [12:0] ref_new;
  logic [12:0] diff;
  logic        check;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mpgc_pkg::ST_IDLE: begin
        if (accept) state_nxt = in_req_type ? mpgc_pkg::ST_FIN : mpgc_pkg::ST_MUL;
      end
      mpgc_pkg::ST_MUL: state_nxt = mpgc_pkg::ST_DIV;
      mpgc_pkg::ST_DIV: begin
        if (cnt_r == mpgc_pkg::DIV_CNT_W'(mpgc_pkg::DIV_STEPS - 1)) state_nxt = mpgc_pkg::ST_ADJ;
      end
      mpgc_pkg::ST_ADJ: state_nxt = mpgc_pkg::ST_TSC;
      mpgc_pkg::ST_TSC: state_nxt = mpgc_pkg::ST_RCP;
      mpgc_pkg::ST_RCP: state_nxt = mpgc_pkg::ST_FIN;
      mpgc_pkg::ST_FIN: begin
        if (fin_go) state_nxt = mpgc_pkg::ST_IDLE;
      end
      default: state_nxt = mpgc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    fin_go   = 1'b0;
    is_rcp   = 1'b0;
    unique case (state_r)
      mpgc_pkg::ST_IDLE: in_stall = 1'b0;
      mpgc_pkg::ST_RCP:  is_rcp = 1'b1;
      mpgc_pkg::ST_FIN:  fin_go = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  assign mul_a = is_rcp ? t_r[20:0] : {5'b0, num_r};
  assign mul_b = is_rcp ? mpgc_pkg::RECIP_M : {6'b0, gain_r};
  assign mul_p = {22'b0, mul_a} * {21'b0, mul_b};

  assign rem_sh = {rem_r, quo_r[31]};
  assign rem_ge = rem_sh >= {1'b0, den_r};

  assign s_full = $signed({2'b0, quo_r}) + 34'(offset_r);
  assign s_ext  = 22'(s_r);
  assign t_calc = (s_ext <<< 4) + (s_ext <<< 2) + mpgc_pkg::SCALE_RND;
  assign t_pos  = !t_r[21] && (t_r != '0);

  // window bookkeeping, evaluated at the finish step
  always_comb begin
    p_new = sat_r ? mpgc_pkg::PRESS_MAX
          : (t_pos ? prod_r[mpgc_pkg::RECIP_SHIFT+12:mpgc_pkg::RECIP_SHIFT] : 13'd0);
    wc_new  = (wcount_r >= wlen_r) ? 8'd0 : wcount_r + 8'd1;
    ref_new = (wc_new == 8'd0) ? p_new : ref_r;
    diff    = (ref_new >= p_new) ? ref_new - p_new : p_new - ref_new;
    check   = (wc_new == wlen_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpgc_pkg::ST_IDLE;
      gain_r      <= '0;
      offset_r    <= '0;
      wlen_r      <= '0;
      thr_r       <= '0;
      wcount_r    <= '0;
      ref_r       <= '0;
      last_r      <= '0;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (mpgc_pkg::cfg_idx_t'(cfg_index))
          mpgc_pkg::CFG_GAIN:      gain_r   <= cfg_data;
          mpgc_pkg::CFG_OFFSET:    offset_r <= $signed(cfg_data);
          mpgc_pkg::CFG_WINDOW:    wlen_r   <= cfg_data[7:0];
          mpgc_pkg::CFG_THRESHOLD: thr_r    <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      if (state_r == mpgc_pkg::ST_MUL) cnt_r <= '0;
      else if (state_r == mpgc_pkg::ST_DIV) cnt_r <= cnt_r + 1'b1;

      if (fin_go) begin
        out_valid_r <= 1'b1;
        if (req_r) begin
          wcount_r <= '0;
        end else begin
          wcount_r <= wc_new;
          last_r   <= p_new;
          ref_r    <= ref_new;
          if (check) fault_r <= (diff > {5'b0, thr_r});
        end
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      num_r <= (in_supply_voltage == '0) ? mpgc_pkg::FALLBACK_RAW : in_raw_pressure;
      den_r <= (in_supply_voltage == '0) ? mpgc_pkg::FALLBACK_DEN : in_supply_voltage;
    end
    unique case (state_r)
      mpgc_pkg::ST_MUL: begin
        quo_r <= mul_p[31:0];
        rem_r <= '0;
      end
      mpgc_pkg::ST_DIV: begin
        rem_r <= rem_ge ? 16'(rem_sh - {1'b0, den_r}) : rem_sh[15:0];
        quo_r <= {quo_r[30:0], rem_ge};
      end
      mpgc_pkg::ST_ADJ: begin
        sat_r <= s_full > mpgc_pkg::Q_LIMIT;
        s_r   <= s_full[17:0];
      end
      mpgc_pkg::ST_TSC: t_r <= t_calc;
      mpgc_pkg::ST_RCP: prod_r <= mul_p;
      default: ;
    endcase
    if (fin_go) begin
      if (req_r) begin
        out_press_r <= last_r;
        out_ref_r   <= ref_r;
        out_wpos_r  <= '0;
        out_fault_r <= fault_r;
        out_done_r  <= 1'b0;
      end else begin
        out_press_r <= p_new;
        out_ref_r   <= ref_new;
        out_wpos_r  <= wc_new;
        out_fault_r <= check ? (diff > {5'b0, thr_r}) : fault_r;
        out_done_r  <= check;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_pressure           = out_press_r;
  assign out_reference_pressure = out_ref_r;
  assign out_window_position    = out_wpos_r;
  assign out_gradient_fault     = out_fault_r;
  assign out_check_done         = out_done_r;

endmodule

// ===== rtl/mpgc_check.sv =====
`timescale 1ns / 1ps
module mpgc_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [12:0] out_pressure,
  input logic [12:0] out_reference_pressure,
  input logic [7:0]  out_window_position
);

  // the unit holds one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pressure)
      && $stable(out_window_position))
    else $error("stalled result changed");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pressure <= 13'd6000 && out_reference_pressure <= 13'd6000)
    else $error("pressure out of range");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind manifold_pressure_gradient_check_unit mpgc_check u_mpgc_check (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_valid),
  .in_stall               (in_stall),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_pressure           (out_pressure),
  .out_reference_pressure (out_reference_pressure),
  .out_window_position    (out_window_position)
);

// ===== tb/manifold_pressure_gradient_check_unit_tb.sv =====
`timescale 1ns / 1ps

module manifold_pressure_gradient_check_unit_tb;

  typedef struct packed {
    logic        req_type;
    logic [15:0] raw_pressure;
    logic [15:0] supply_voltage;
  } press_item_t;

  typedef struct packed {
    logic [12:0] pressure;
    logic [12:0] reference_pressure;
    logic [7:0]  window_position;
    logic        gradient_fault;
    logic        check_done;
  } gauge_reading_t;

  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type;
  logic [15:0] in_raw_pressure;
  logic [15:0] in_supply_voltage;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [12:0] out_pressure;
  logic [12:0] out_reference_pressure;
  logic [7:0]  out_window_position;
  logic        out_gradient_fault;
  logic        out_check_done;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = mpgc_pkg::CFG_GAIN;
  logic [15:0] cfg_data = 16'd0;

  press_item_t    held_item = '0;
  press_item_t    sample_queue[$];
  gauge_reading_t expected_readings[$];

  // predictor copy of registers and state
  logic [15:0]        gain_reg = '0;
  logic signed [15:0] offset_reg = '0;
  logic [7:0]         window_reg = '0;
  logic [7:0]         thresh_reg = '0;
  logic [7:0]         win_count = '0;
  logic [12:0]        ref_press = '0;
  logic [12:0]        last_press = '0;
  logic               fault_flag = 1'b0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned items_queued = 0;
  int unsigned readings_seen = 0;
  int unsigned error_count = 0;
  logic [15:0] base_raw = 16'd20000;
  logic [15:0] base_supply = 16'd30000;

  assign in_req_type       = held_item.req_type;
  assign in_raw_pressure   = held_item.raw_pressure;
  assign in_supply_voltage = held_item.supply_voltage;

  manifold_pressure_gradient_check_unit i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_req_type            (in_req_type),
    .in_raw_pressure        (in_raw_pressure),
    .in_supply_voltage      (in_supply_voltage),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_pressure           (out_pressure),
    .out_reference_pressure (out_reference_pressure),
    .out_window_position    (out_window_position),
    .out_gradient_fault     (out_gradient_fault),
    .out_check_done         (out_check_done),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [12:0] scale_pressure(logic [15:0] raw, logic [15:0] supply);
    logic [15:0] num;
    logic [15:0] den;
    logic [31:0] quot;
    longint      off;
    longint      t;
    num  = raw;
    den  = supply;
    off  = longint'(offset_reg);
    if (den == 16'd0) begin
      num = 16'hFFFF;
      den = 16'd1;
    end
    quot = (32'(num) * 32'(gain_reg)) / 32'(den);
    if (longint'(quot) > 75000 - off) return 13'd6000;
    t = (longint'(quot) + off) * 20 + 125;
    if (t <= 0) return 13'd0;
    return 13'(t / 250);
  endfunction

  function automatic gauge_reading_t predict_reading(press_item_t it);
    gauge_reading_t r;
    logic [12:0]    p;
    logic [12:0]    diff;
    logic           done;
    done = 1'b0;
    if (it.req_type == REQ_RESTART) begin
      win_count = '0;
    end else begin
      p = scale_pressure(it.raw_pressure, it.supply_voltage);
      last_press = p;
      // a counter left above a lowered window length wraps like a normal window end
      if (win_count >= window_reg) win_count = '0;
      else win_count = win_count + 8'd1;
      if (win_count == 8'd0) ref_press = (p > 13'd6000) ? 13'd6000 : p;
      if (win_count == window_reg) begin
        diff = (ref_press >= p) ? ref_press - p : p - ref_press;
        fault_flag = (diff > 13'(thresh_reg));
        done = 1'b1;
      end
    end
    r.pressure           = last_press;
    r.reference_pressure = ref_press;
    r.window_position    = win_count;
    r.gradient_fault     = fault_flag;
    r.check_done         = done;
    return r;
  endfunction

  // driver: payload stays put while stalled, valid is never withdrawn
  always @(posedge clk) begin
    press_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_readings.push_back(predict_reading(held_item));
      if (!in_valid || !in_stall) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = sample_queue.pop_front();
          held_item <= nxt;
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    gauge_reading_t got;
    gauge_reading_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_pressure, out_reference_pressure, out_window_position,
                out_gradient_fault, out_check_done};
        if (expected_readings.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected result item: %p", got);
        end else begin
          want = expected_readings.pop_front();
          readings_seen++;
          if (got.pressure !== want.pressure ||
              got.reference_pressure !== want.reference_pressure ||
              got.window_position !== want.window_position ||
              got.gradient_fault !== want.gradient_fault ||
              got.check_done !== want.check_done) begin
            error_count++;
            if (error_count <= 10)
              $display("mismatch at result %0d: expected %p, actual %p",
                       readings_seen, want, got);
          end
        end
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic set_register(input mpgc_pkg::cfg_idx_t idx, input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      mpgc_pkg::CFG_GAIN:      gain_reg = value;
      mpgc_pkg::CFG_OFFSET:    offset_reg = value;
      mpgc_pkg::CFG_WINDOW:    window_reg = value[7:0];
      mpgc_pkg::CFG_THRESHOLD: thresh_reg = value[7:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [15:0] gain, input logic [15:0] offset,
                           input logic [7:0] window, input logic [7:0] thresh);
    set_register(mpgc_pkg::CFG_GAIN, gain);
    set_register(mpgc_pkg::CFG_OFFSET, offset);
    set_register(mpgc_pkg::CFG_WINDOW, {8'd0, window});
    set_register(mpgc_pkg::CFG_THRESHOLD, {8'd0, thresh});
  endtask

  task automatic queue_item(input logic req, input logic [15:0] raw, input logic [15:0] supply);
    press_item_t it;
    it.req_type       = req;
    it.raw_pressure   = raw;
    it.supply_voltage = supply;
    sample_queue.push_back(it);
    items_queued++;
  endtask

  // slow-moving sample streams so the threshold compare sees small deltas, mixed
  // with restarts, zero-supply samples and fully random samples
  task automatic queue_random(input int n, input int unsigned restart_pct);
    int unsigned pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if ($urandom_range(19) == 0) begin
        base_raw    = 16'($urandom);
        base_supply = 16'($urandom_range(65535, 1));
      end
      if (pick < restart_pct)
        queue_item(REQ_RESTART, 16'($urandom), 16'($urandom));
      else if (pick < 55)
        queue_item(REQ_SAMPLE, base_raw + 16'($urandom_range(6)) - 16'd3, base_supply);
      else if (pick < 61)
        queue_item(REQ_SAMPLE, 16'($urandom), 16'd0);
      else
        queue_item(REQ_SAMPLE, 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic drain;
    while (readings_seen != items_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 29;
    rx_idle_pct = 51;
    configure(16'hFFFF, 16'd0, 8'd3, 8'd0);
    queue_item(REQ_SAMPLE, 16'd0, 16'd1);
    queue_item(REQ_SAMPLE, 16'hFFFF, 16'd1);
    queue_item(REQ_SAMPLE, 16'd0, 16'd0);        // zero supply fallback
    queue_item(REQ_SAMPLE, 16'hFFFF, 16'hFFFF);
    queue_item(REQ_SAMPLE, 16'd1, 16'hFFFF);
    queue_item(REQ_SAMPLE, 16'd1000, 16'd30000);
    queue_item(REQ_RESTART, 16'hFFFF, 16'hFFFF);
    queue_item(REQ_RESTART, 16'd0, 16'd0);
    queue_item(REQ_SAMPLE, 16'h8000, 16'h8000);
    queue_item(REQ_SAMPLE, 16'h8000, 16'h8000);
    queue_item(REQ_SAMPLE, 16'h8000, 16'h8000);
    queue_item(REQ_SAMPLE, 16'h8000, 16'h8000);  // window wraps, sample becomes the reference
    queue_item(REQ_SAMPLE, 16'h5555, 16'hAAAA);
    queue_item(REQ_SAMPLE, 16'hAAAA, 16'h5555);
    queue_item(REQ_SAMPLE, 16'h0100, 16'hFFFF);
    queue_item(REQ_SAMPLE, 16'h0101, 16'hFFFF);  // window wraps, sample becomes the reference
    queue_item(REQ_RESTART, 16'h5555, 16'hAAAA);
    queue_item(REQ_SAMPLE, 16'hFFFF, 16'd0);
    queue_item(REQ_SAMPLE, 16'd7, 16'd3);
    queue_item(REQ_SAMPLE, 16'd2, 16'd65534);
    queue_random(130, 10);
    drain();

    // zero window, most negative offset: every sample freezes then checks
    configure(16'd0, 16'h8000, 8'd0, 8'd255);
    queue_random(100, 10);
    drain();

    tx_idle_pct = 51;
    rx_idle_pct = 29;
    // long window, no restarts so the counter climbs high
    configure(16'd1234, 16'h7FFF, 8'd255, 8'd128);
    queue_random(200, 0);
    drain();

    // lowered window leaves the counter above it
    configure(16'd40000, 16'hFC18, 8'd7, 8'd50);
    queue_random(150, 10);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure(16'd20000, 16'd500, 8'd1, 8'd3);
    queue_random(150, 10);
    drain();

    configure(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    queue_random(150, 10);
    drain();

    repeat (50) @(posedge clk);
    if (expected_readings.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("manifold_pressure_gradient_check_unit verification clean");
    end else begin
      $display("manifold_pressure_gradient_check_unit verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("manifold_pressure_gradient_check_unit verification failed");
    $finish;
  end

endmodule
